// File: sv/irbwc_pkg.sv
package irbwc_pkg;

	// Field widths.
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned SCALE_W = 21;
	localparam int unsigned CODE_W  = 3;
	localparam int unsigned IDX_W   = 3;

	// Frame phases.
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_GAP1  = 3'd2;
	localparam logic [2:0] PH_DATA1 = 3'd3;
	localparam logic [2:0] PH_GAP2  = 3'd4;
	localparam logic [2:0] PH_DATA2 = 3'd5;

	// Result codes.
	localparam logic [CODE_W-1:0] EV_DAMAGE   = 3'd0;
	localparam logic [CODE_W-1:0] EV_HEAL     = 3'd1;
	localparam logic [CODE_W-1:0] EV_STUN     = 3'd2;
	localparam logic [CODE_W-1:0] EV_NONE     = 3'd3;
	localparam logic [CODE_W-1:0] EV_MISMATCH = 3'd4;
	localparam logic [CODE_W-1:0] EV_TIMEOUT  = 3'd5;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_TIMEOUT     = 3'd0;
	localparam logic [IDX_W-1:0] REG_DAMAGE_LOW  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DAMAGE_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] REG_HEAL_LOW    = 3'd3;
	localparam logic [IDX_W-1:0] REG_HEAL_HIGH   = 3'd4;
	localparam logic [IDX_W-1:0] REG_STUN_LOW    = 3'd5;
	localparam logic [IDX_W-1:0] REG_STUN_HIGH   = 3'd6;

	// Register reset values.
	localparam logic [TICK_W-1:0]  RST_TIMEOUT     = 16'd2678;
	localparam logic [SCALE_W-1:0] RST_DAMAGE_LOW  = 21'd6000;
	localparam logic [SCALE_W-1:0] RST_DAMAGE_HIGH = 21'd7500;
	localparam logic [SCALE_W-1:0] RST_HEAL_LOW    = 21'd10000;
	localparam logic [SCALE_W-1:0] RST_HEAL_HIGH   = 21'd12000;
	localparam logic [SCALE_W-1:0] RST_STUN_LOW    = 21'd13000;
	localparam logic [SCALE_W-1:0] RST_STUN_HIGH   = 21'd15000;

	// Scaling by 17.85 is avg*357/20: multiply by 357, drop two bits, then
	// divide by five as a multiply by ceil(2^25/5) and a shift of 25. The
	// quotient is exact for every dividend below 2^25/3, and the largest one
	// here is about 5.85 million.
	localparam logic [8:0]  SCALE_MUL = 9'd357;
	localparam logic [22:0] RECIP_5   = 23'd6710887;
	localparam int unsigned RECIP_SH  = 25;

endpackage

// File: sv/ir_burst_width_classifier.sv
// IR burst width classifier.
//
// The input channel (in_valid, in_ready, ir_level) takes one sample of the
// active-low IR line per microsecond tick; each accepted request is one tick.
// A level change while idle opens a frame of start burst, gap, first data
// burst, gap and redundant data burst. The two data bursts are measured,
// cross-checked to within 10%, averaged, scaled by 17.85 and classified.
// At most one result leaves on the output channel (out_valid, out_ready,
// event_code, average_width, scaled_width) per frame: at its end or timeout.
// Throughput is one sample per cycle while in_ready is high. A result moves
// through the pipeline registers in order after the sample ending its frame
// is accepted: the first takes the two widths, the next cross-checks and
// averages them and multiplies by 357, the next divides by 20, and the last
// sorts the result into its window and loads the output register.
// When the receiver stalls with a result waiting, the whole result pipeline
// and the input stall together, so in_ready follows out_ready.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should only be written while no frame result is in flight.
// Reset (arst_n low) restores the register defaults, returns to idle with the
// line taken as high, and empties the result pipeline.
module ir_burst_width_classifier
	import irbwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               ir_level,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [SCALE_W-1:0] cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CODE_W-1:0]  event_code,
	output logic [TICK_W-1:0]  average_width,
	output logic [SCALE_W-1:0] scaled_width
);

	// Configuration registers.
	logic [TICK_W-1:0]  timeout_q;
	logic [SCALE_W-1:0] damage_low_q, damage_high_q;
	logic [SCALE_W-1:0] heal_low_q, heal_high_q;
	logic [SCALE_W-1:0] stun_low_q, stun_high_q;

	// Frame tracking state.
	logic [2:0]        phase_q, phase_d;
	logic [TICK_W-1:0] tick_q, tick_d, tick_inc;
	logic [TICK_W-1:0] first_q, first_d;
	logic              prev_q;

	// Result pipeline.
	logic              adv;
	logic              in_fire;
	logic              emit;
	logic              emit_tmo;
	logic              v_s1, v_s2, v_s3;
	logic              tmo_s1, tmo_s2, tmo_s3;
	logic [TICK_W-1:0] a_s1, b_s1;
	logic              bad_s2, bad_s3;
	logic [TICK_W-1:0] avg_s2, avg_s3;
	logic [24:0]       prod_s2;
	logic [SCALE_W-1:0] scaled_s3;
	logic              out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic [TICK_W-1:0] avg_q;
	logic [SCALE_W-1:0] scaled_q;

	logic              want_level;
	logic [19:0]       a_x10, b_x10, a_x11, b_x11;
	logic [16:0]       sum_ab;
	logic [22:0]       quarter;
	logic [45:0]       div_prod;
	logic [CODE_W-1:0] code_d;

	// The whole result path moves only when the output register can take
	// a new value, and the sampler moves with it.
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= RST_TIMEOUT;
			damage_low_q  <= RST_DAMAGE_LOW;
			damage_high_q <= RST_DAMAGE_HIGH;
			heal_low_q    <= RST_HEAL_LOW;
			heal_high_q   <= RST_HEAL_HIGH;
			stun_low_q    <= RST_STUN_LOW;
			stun_high_q   <= RST_STUN_HIGH;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIMEOUT:     timeout_q     <= cfg_data[TICK_W-1:0];
				REG_DAMAGE_LOW:  damage_low_q  <= cfg_data;
				REG_DAMAGE_HIGH: damage_high_q <= cfg_data;
				REG_HEAL_LOW:    heal_low_q    <= cfg_data;
				REG_HEAL_HIGH:   heal_high_q   <= cfg_data;
				REG_STUN_LOW:    stun_low_q    <= cfg_data;
				REG_STUN_HIGH:   stun_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Phase sequencer. The gaps are high phases, the bursts low ones; a tick
	// at the opposite level is the first tick of the next phase.
	assign want_level = (phase_q == PH_GAP1) || (phase_q == PH_GAP2);
	assign tick_inc   = (tick_q == {TICK_W{1'b1}}) ? tick_q : tick_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		first_d  = first_q;
		emit     = 1'b0;
		emit_tmo = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (ir_level != prev_q) begin
				phase_d = ir_level ? PH_GAP1 : PH_START;
				tick_d  = {{(TICK_W-1){1'b0}}, 1'b1};
			end
		end else if (ir_level == want_level) begin
			// A timeout of zero behaves as one, since tick_inc is never zero.
			if (tick_inc >= timeout_q) begin
				phase_d  = PH_IDLE;
				tick_d   = '0;
				emit     = 1'b1;
				emit_tmo = 1'b1;
			end else begin
				tick_d = tick_inc;
			end
		end else begin
			tick_d = {{(TICK_W-1){1'b0}}, 1'b1};
			case (phase_q)
				PH_START: phase_d = PH_GAP1;
				PH_GAP1:  phase_d = PH_DATA1;
				PH_DATA1: begin
					first_d = tick_q;
					phase_d = PH_GAP2;
				end
				PH_GAP2:  phase_d = PH_DATA2;
				default: begin
					phase_d = PH_IDLE;
					tick_d  = '0;
					emit    = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			first_q <= '0;
			prev_q  <= 1'b1;
		end else if (in_fire) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			first_q <= first_d;
			prev_q  <= ir_level;
		end
	end

	// Stage two: the cross-check 10a <= 11b both ways, the mean and the
	// first scaling product.
	assign a_x10  = {1'b0, a_s1, 3'b000} + {3'b000, a_s1, 1'b0};
	assign b_x10  = {1'b0, b_s1, 3'b000} + {3'b000, b_s1, 1'b0};
	assign a_x11  = a_x10 + {4'b0000, a_s1};
	assign b_x11  = b_x10 + {4'b0000, b_s1};
	assign sum_ab = {1'b0, a_s1} + {1'b0, b_s1};

	// Stage three: divide by four, then by five through the reciprocal.
	assign quarter  = prod_s2[24:2];
	assign div_prod = 46'(quarter) * 46'(RECIP_5);

	// Output stage: windows in priority order damage, heal, stun.
	always_comb begin
		if (tmo_s3) begin
			code_d = EV_TIMEOUT;
		end else if (bad_s3) begin
			code_d = EV_MISMATCH;
		end else if (scaled_s3 >= damage_low_q && scaled_s3 < damage_high_q) begin
			code_d = EV_DAMAGE;
		end else if (scaled_s3 >= heal_low_q && scaled_s3 < heal_high_q) begin
			code_d = EV_HEAL;
		end else if (scaled_s3 >= stun_low_q && scaled_s3 < stun_high_q) begin
			code_d = EV_STUN;
		end else begin
			code_d = EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_fire && emit;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tmo_s1    <= emit_tmo;
			a_s1      <= first_q;
			b_s1      <= tick_q;
			tmo_s2    <= tmo_s1;
			bad_s2    <= (a_x10 > b_x11) || (b_x10 > a_x11);
			avg_s2    <= sum_ab[16:1];
			prod_s2   <= 25'(sum_ab[16:1]) * 25'(SCALE_MUL);
			tmo_s3    <= tmo_s2;
			bad_s3    <= bad_s2;
			avg_s3    <= avg_s2;
			scaled_s3 <= div_prod[RECIP_SH +: SCALE_W];
			code_q    <= code_d;
			avg_q     <= (tmo_s3 || bad_s3) ? '0 : avg_s3;
			scaled_q  <= (tmo_s3 || bad_s3) ? '0 : scaled_s3;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_code    = code_q;
	assign average_width = avg_q;
	assign scaled_width  = scaled_q;

	// The tick counter is zero exactly when no frame is open.
	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) == (tick_q == '0))
		else $error("tick counter out of step with frame phase");

	// A sample taken while idle never produces a result.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == PH_IDLE |=> !v_s1)
		else $error("result raised from idle");

	// Aborted and rejected frames carry no widths.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (code_q == EV_TIMEOUT || code_q == EV_MISMATCH)
		|-> avg_q == '0 && scaled_q == '0)
		else $error("widths reported on a failed frame");

	// A result already in flight keeps moving while the output is free.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> out_valid_q)
		else $error("result lost between last stage and output");

endmodule

// File: test/ir_burst_event_checker.sv
module ir_burst_event_checker
	import irbwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               ir_level,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [SCALE_W-1:0] cfg_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [CODE_W-1:0]  event_code,
	input  logic [TICK_W-1:0]  average_width,
	input  logic [SCALE_W-1:0] scaled_width,
	output int                 mismatches,
	output int                 events_pending
);

	localparam int unsigned SCALE_NUM  = 1785;
	localparam int unsigned SCALE_DEN  = 100;
	localparam int unsigned REPORT_MAX = 10;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [TICK_W-1:0]  avg;
		logic [SCALE_W-1:0] scaled;
	} burst_event_t;

	burst_event_t expected_events[$];

	// Our own copy of the registers.
	logic [TICK_W-1:0]  timeout_reg;
	logic [SCALE_W-1:0] damage_lo, damage_hi, heal_lo, heal_hi, stun_lo, stun_hi;

	// Our own copy of the frame tracker.
	logic [2:0]        phase;
	logic [TICK_W-1:0] run_len;
	logic [TICK_W-1:0] first_w;
	logic              prev_level;

	int fail_count;
	int events_seen;

	task automatic store_reg(input logic [IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
		case (idx)
			REG_TIMEOUT:     timeout_reg = value[TICK_W-1:0];
			REG_DAMAGE_LOW:  damage_lo = value;
			REG_DAMAGE_HIGH: damage_hi = value;
			REG_HEAL_LOW:    heal_lo = value;
			REG_HEAL_HIGH:   heal_hi = value;
			REG_STUN_LOW:    stun_lo = value;
			REG_STUN_HIGH:   stun_hi = value;
			default: begin
			end
		endcase
	endtask

	task automatic close_frame(input logic [TICK_W-1:0] second);
		int unsigned a, b, mean, scaled;
		burst_event_t ev;
		a = first_w;
		b = second;
		ev.code = EV_MISMATCH;
		ev.avg = '0;
		ev.scaled = '0;
		// Both widths must lie within ten per cent of each other.
		if (10 * a <= 11 * b && 10 * b <= 11 * a) begin
			mean = (a + b) / 2;
			scaled = mean * SCALE_NUM / SCALE_DEN;
			ev.avg = mean[TICK_W-1:0];
			ev.scaled = scaled[SCALE_W-1:0];
			if (scaled >= damage_lo && scaled < damage_hi) begin
				ev.code = EV_DAMAGE;
			end else if (scaled >= heal_lo && scaled < heal_hi) begin
				ev.code = EV_HEAL;
			end else if (scaled >= stun_lo && scaled < stun_hi) begin
				ev.code = EV_STUN;
			end else begin
				ev.code = EV_NONE;
			end
		end
		expected_events.push_back(ev);
	endtask

	task automatic take_sample(input logic level);
		logic want;
		burst_event_t ev;
		if (phase == PH_IDLE) begin
			if (level != prev_level) begin
				phase = level ? PH_GAP1 : PH_START;
				run_len = TICK_W'(1);
			end
		end else begin
			want = (phase == PH_GAP1 || phase == PH_GAP2);
			if (level == want) begin
				if (run_len != '1)
					run_len = run_len + 1'b1;
				if (run_len >= timeout_reg) begin
					phase = PH_IDLE;
					run_len = '0;
					ev.code = EV_TIMEOUT;
					ev.avg = '0;
					ev.scaled = '0;
					expected_events.push_back(ev);
				end
			end else begin
				case (phase)
					PH_START: phase = PH_GAP1;
					PH_GAP1:  phase = PH_DATA1;
					PH_DATA1: begin
						first_w = run_len;
						phase = PH_GAP2;
					end
					PH_GAP2:  phase = PH_DATA2;
					default: begin
						close_frame(run_len);
						phase = PH_IDLE;
					end
				endcase
				run_len = (phase == PH_IDLE) ? '0 : TICK_W'(1);
			end
		end
		prev_level = level;
	endtask

	task automatic check_event();
		burst_event_t want_ev;
		events_seen++;
		if (expected_events.size() == 0) begin
			if (fail_count < REPORT_MAX)
				$display("burst event %0d arrived unasked: code %0d avg %0d scaled %0d",
					events_seen, event_code, average_width, scaled_width);
			fail_count++;
		end else begin
			want_ev = expected_events.pop_front();
			if (event_code !== want_ev.code || average_width !== want_ev.avg
				|| scaled_width !== want_ev.scaled) begin
				if (fail_count < REPORT_MAX) begin
					$display("burst event %0d wrong: expected code %0d avg %0d scaled %0d",
						events_seen, want_ev.code, want_ev.avg, want_ev.scaled);
					$display("burst event %0d wrong: got code %0d avg %0d scaled %0d",
						events_seen, event_code, average_width, scaled_width);
				end
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_reg = RST_TIMEOUT;
			damage_lo = RST_DAMAGE_LOW;
			damage_hi = RST_DAMAGE_HIGH;
			heal_lo = RST_HEAL_LOW;
			heal_hi = RST_HEAL_HIGH;
			stun_lo = RST_STUN_LOW;
			stun_hi = RST_STUN_HIGH;
			phase = PH_IDLE;
			run_len = '0;
			first_w = '0;
			prev_level = 1'b1;
			expected_events.delete();
			fail_count = 0;
			events_seen = 0;
			mismatches <= 0;
			events_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				store_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				take_sample(ir_level);
			if (out_valid && out_ready)
				check_event();
			mismatches <= fail_count;
			events_pending <= expected_events.size();
		end
	end

endmodule

// File: test/tb_ir_burst_width_classifier.sv
// Stimulus and verdict for the IR burst width classifier. The checker beside
// the block watches all three channels, keeps its own model of the frame
// tracker and compares every result request; this module only drives the
// line samples, the register writes and the receiver's readiness.
module tb_ir_burst_width_classifier;
	import irbwc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 50000;
	// Cycles to let pass once nothing is expected, so that the result pipeline
	// is surely empty.
	localparam int unsigned QUIET_CYCLES = 8;
	localparam int unsigned HOLD_LEN = 400;
	// The register map leaves index seven unused; writing it must do nothing.
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [SCALE_W-1:0] SCALE_MAX = 21'h1FFFFF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               ir_level = 1'b1;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = REG_TIMEOUT;
	logic [SCALE_W-1:0] cfg_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CODE_W-1:0]  event_code;
	logic [TICK_W-1:0]  average_width;
	logic [SCALE_W-1:0] scaled_width;

	int mismatches;
	int events_pending;

	// Idling rates in per cent, the timeout currently loaded, and the count of
	// samples sent so far.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned cur_timeout = RST_TIMEOUT;
	int unsigned ticks_sent = 0;
	int unsigned cycle_count = 0;

	// The receiver notices a new hold when this count moves on.
	int unsigned hold_requests = 0;
	int unsigned holds_taken = 0;
	int unsigned hold_left = 0;

	always #10 clk = ~clk;

	ir_burst_width_classifier u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.ir_level      (ir_level),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_code    (event_code),
		.average_width (average_width),
		.scaled_width  (scaled_width)
	);

	ir_burst_event_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ir_level       (ir_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_code     (event_code),
		.average_width  (average_width),
		.scaled_width   (scaled_width),
		.mismatches     (mismatches),
		.events_pending (events_pending)
	);

	// Receiver. A hold keeps out_ready low for a long run of cycles, counted
	// here, so that results pile up in the block and it refuses samples.
	// Otherwise readiness is drawn afresh each cycle at the current rate.
	always @(posedge clk) begin
		if (hold_requests != holds_taken) begin
			holds_taken <= hold_requests;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic set_idling(input int unsigned tx, input int unsigned rx);
		tx_idle_pct = tx;
		rx_idle_pct <= rx;
	endtask

	// One line sample. The valid is only dropped when the sender decides to
	// idle, so back-to-back requests never see valid lowered and raised in the
	// same step.
	task automatic send_tick(input logic level);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ir_level <= level;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	task automatic send_run(input logic level, input int unsigned n);
		repeat (n)
			send_tick(level);
	endtask

	// A whole frame from an idle, high line: start burst, gap, first data
	// burst, gap, redundant data burst, and the rising edge that closes it.
	task automatic send_frame(input int unsigned s, g1, w1, g2, w2);
		send_run(1'b0, s);
		send_run(1'b1, g1);
		send_run(1'b0, w1);
		send_run(1'b1, g2);
		send_run(1'b0, w2);
		send_tick(1'b1);
	endtask

	// Enough high samples to let any open frame run out its timeout, leaving
	// the block idle with the line high.
	task automatic resync();
		send_run(1'b1, ((cur_timeout > 1) ? cur_timeout : 1) + 1);
	endtask

	// Stop offering samples and wait until every predicted result has been
	// taken, then a few cycles more so the pipeline is surely empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_pending != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_config(input logic [TICK_W-1:0] t,
		input logic [SCALE_W-1:0] dl, dh, hl, hh, sl, sh, input bit poke_spare);
		if (poke_spare)
			write_reg(REG_SPARE, SCALE_W'($urandom));
		write_reg(REG_TIMEOUT, SCALE_W'(t));
		write_reg(REG_DAMAGE_LOW, dl);
		write_reg(REG_DAMAGE_HIGH, dh);
		write_reg(REG_HEAL_LOW, hl);
		write_reg(REG_HEAL_HIGH, hh);
		write_reg(REG_STUN_LOW, sl);
		write_reg(REG_STUN_HIGH, sh);
		cfg_valid <= 1'b0;
		cur_timeout = t;
	endtask

	// Windows sized for the short bursts of the random part, where widths up
	// to about thirty ticks scale to roughly five hundred. They overlap at times.
	task automatic load_random_config(input int unsigned t_lo, input int unsigned t_hi);
		logic [SCALE_W-1:0] dl, hl, sl;
		dl = SCALE_W'($urandom_range(300));
		hl = SCALE_W'($urandom_range(600));
		sl = SCALE_W'($urandom_range(900));
		load_config(TICK_W'($urandom_range(t_hi, t_lo)),
			dl, dl + SCALE_W'($urandom_range(400)),
			hl, hl + SCALE_W'($urandom_range(400)),
			sl, sl + SCALE_W'($urandom_range(400)), 1'b0);
	endtask

	// A phase length of at most the given count that will not time out.
	function automatic int unsigned pick_len(input int unsigned most);
		int unsigned cap;
		cap = (cur_timeout > 1) ? cur_timeout - 1 : 1;
		if (most > cap)
			most = cap;
		return $urandom_range(most, 1);
	endfunction

	// Mostly well-formed frames with random timing; the rest are frames with
	// widths just outside the ten per cent band, frames that overrun one phase,
	// and plain line noise. Anything that may leave a frame open is followed
	// by a resync.
	task automatic random_frame();
		int unsigned kind, cap, w1, w2, lo, hi, hi_raw, spot, over, i;
		int unsigned lens[5];
		kind = $urandom_range(99);
		cap = (cur_timeout > 1) ? cur_timeout - 1 : 1;
		w1 = ($urandom_range(9) == 0) ? pick_len(cap) : pick_len(30);
		// Smallest and largest second widths that still pass the cross-check.
		lo = (10 * w1 + 10) / 11;
		hi_raw = (11 * w1) / 10;
		hi = (hi_raw > cap) ? cap : hi_raw;
		if (kind < 70) begin
			w2 = $urandom_range(hi, lo);
			send_frame(pick_len(6), pick_len(6), w1, pick_len(6), w2);
			send_run(1'b1, $urandom_range(4));
		end else if (kind < 80) begin
			if (hi_raw < cap && (lo == 1 || $urandom_range(1) == 1)) begin
				w2 = $urandom_range((cap < hi_raw + 6) ? cap : hi_raw + 6, hi_raw + 1);
			end else if (lo > 1) begin
				w2 = $urandom_range(lo - 1, 1);
			end else begin
				// No failing width fits under this timeout.
				w2 = w1;
			end
			send_frame(pick_len(6), pick_len(6), w1, pick_len(6), w2);
		end else if (kind < 90) begin
			lens[0] = pick_len(6);
			lens[1] = pick_len(6);
			lens[2] = w1;
			lens[3] = pick_len(6);
			lens[4] = w1;
			spot = $urandom_range(4);
			over = ((cur_timeout > 1) ? cur_timeout : 1) + $urandom_range(3);
			lens[spot] = over;
			for (i = 0; i <= spot; i++)
				send_run(i[0], lens[i]);
			resync();
		end else begin
			repeat ($urandom_range(30, 1))
				send_tick(1'($urandom_range(1)));
			resync();
		end
	endtask

	task automatic random_phase(input int unsigned tx, input int unsigned rx,
		input int unsigned t_lo, input int unsigned t_hi);
		int unsigned frames, first_tick;
		settle();
		set_idling(tx, rx);
		load_random_config(t_lo, t_hi);
		frames = 0;
		first_tick = ticks_sent;
		while (frames < 3 || ticks_sent - first_tick < 60) begin
			random_frame();
			frames++;
		end
	endtask

	// Watchdog: a correct run finishes well inside this many cycles.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		set_idling(19, 46);
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults straight out of reset: a short frame that falls in
		// no window, and one whose widths fall just outside the band.
		send_frame(3, 4, 10, 4, 11);
		send_frame(3, 4, 12, 4, 10);

		// A zero timeout behaves as one: only single-tick phases survive. The
		// damage window covers everything. A start burst that times out leaves
		// the line low, so the next rising edge opens a frame at its first gap.
		settle();
		load_config(16'd0, '0, SCALE_MAX, SCALE_W'($urandom_range(SCALE_MAX)),
			SCALE_W'($urandom_range(SCALE_MAX)), SCALE_W'($urandom_range(SCALE_MAX)),
			SCALE_W'($urandom_range(SCALE_MAX)), 1'b1);
		send_frame(1, 1, 1, 1, 1);
		send_run(1'b0, 2);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);

		// Timeout of one, a one-wide damage window, and two empty windows: one
		// with equal bounds and one with both at zero.
		settle();
		load_config(16'd1, 21'd17, 21'd18, SCALE_MAX, SCALE_MAX, '0, '0, 1'b0);
		send_frame(1, 1, 1, 1, 1);
		send_tick(1'b0);
		send_run(1'b1, 2);

		// Windows that abut and overlap around the scaled values of widths ten to
		// thirteen, so the damage and stun low bounds are hit exactly; heal wins over
		// stun where they overlap. Then small width pairs, most failing the cross-check.
		settle();
		load_config(16'd100, 21'd178, 21'd179, 21'd179, 21'd197, 21'd196, 21'd215, 1'b0);
		send_frame(2, 2, 10, 2, 10);
		send_frame(2, 2, 11, 2, 11);
		send_frame(2, 2, 12, 2, 12);
		send_frame(2, 2, 13, 2, 13);
		send_frame(2, 2, 10, 2, 11);
		send_frame(2, 2, 10, 2, 12);
		send_frame(2, 2, 12, 2, 10);
		send_frame(2, 2, 1, 2, 2);

		// Random part under the three idling patterns.
		random_phase(19, 46, 8, 24);
		random_phase(46, 19, 2, 12);
		random_phase(0, 0, 10, 30);

		// The receiver holds off for a long stretch while a string of short
		// frames keeps coming, so results back up and the input stalls.
		hold_requests <= hold_requests + 1;
		repeat (12)
			send_frame(1, 1, 1, 1, 1);

		settle();
		if (mismatches == 0 && events_pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
